// ===== rtl/owb_pkg.sv =====
// ----------------------------------------------------------------------------
// owb_pkg: shared types and constants for the 1-Wire bus master
// Beat formats, phase and command codes, register indexes and reset timings.
// ----------------------------------------------------------------------------
package owb_pkg;

  localparam int TimeW = 10;

  // One input beat: one microsecond tick
  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] req_type;
    logic [7:0] write_data;
    logic       line_level;
  } in_item_t;

  // One result beat
  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       no_presence;
  } res_item_t;

  // A classified tick as it sits in the queue
  typedef struct packed {
    logic       start_ok;
    logic [2:0] req_type;
    logic [7:0] write_data;
    logic       line_level;
  } tick_t;

  // Queue status seen by the top level
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Timing registers
  typedef struct packed {
    logic [TimeW-1:0] reset_low_time;
    logic [TimeW-1:0] presence_sample_time;
    logic [TimeW-1:0] reset_tail_time;
    logic [TimeW-1:0] slot_low_time;
    logic [TimeW-1:0] read_sample_time;
    logic [TimeW-1:0] write_hold_time;
    logic [TimeW-1:0] read_tail_time;
    logic [TimeW-1:0] recovery_time;
  } timing_t;

  // Register indexes
  localparam logic [2:0] REG_RESET_LOW       = 3'd0;
  localparam logic [2:0] REG_PRESENCE_SAMPLE = 3'd1;
  localparam logic [2:0] REG_RESET_TAIL      = 3'd2;
  localparam logic [2:0] REG_SLOT_LOW        = 3'd3;
  localparam logic [2:0] REG_READ_SAMPLE     = 3'd4;
  localparam logic [2:0] REG_WRITE_HOLD      = 3'd5;
  localparam logic [2:0] REG_READ_TAIL       = 3'd6;
  localparam logic [2:0] REG_RECOVERY        = 3'd7;

  // Reset timings in ticks
  localparam logic [TimeW-1:0] RST_RESET_LOW       = 10'd480;
  localparam logic [TimeW-1:0] RST_PRESENCE_SAMPLE = 10'd120;
  localparam logic [TimeW-1:0] RST_RESET_TAIL      = 10'd360;
  localparam logic [TimeW-1:0] RST_SLOT_LOW        = 10'd2;
  localparam logic [TimeW-1:0] RST_READ_SAMPLE     = 10'd8;
  localparam logic [TimeW-1:0] RST_WRITE_HOLD      = 10'd58;
  localparam logic [TimeW-1:0] RST_READ_TAIL       = 10'd50;
  localparam logic [TimeW-1:0] RST_RECOVERY        = 10'd2;

  // Commands
  localparam logic [2:0] CMD_RESET = 3'd0;
  localparam logic [2:0] CMD_WBYTE = 3'd1;
  localparam logic [2:0] CMD_RBYTE = 3'd2;
  localparam logic [2:0] CMD_WBIT  = 3'd3;
  localparam logic [2:0] CMD_RBIT  = 3'd4;

  // Bus phases
  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_RST_LOW  = 4'd1;
  localparam logic [3:0] PH_RST_WAIT = 4'd2;
  localparam logic [3:0] PH_RST_TAIL = 4'd3;
  localparam logic [3:0] PH_SLOT_LOW = 4'd4;
  localparam logic [3:0] PH_WR_HOLD  = 4'd5;
  localparam logic [3:0] PH_RD_WAIT  = 4'd6;
  localparam logic [3:0] PH_RD_TAIL  = 4'd7;
  localparam logic [3:0] PH_RECOVER  = 4'd8;

  localparam logic [3:0] BITS_BYTE = 4'd8;
  localparam logic [3:0] BITS_ONE  = 4'd1;

endpackage

// ===== rtl/owb_front.sv =====
// ----------------------------------------------------------------------------
// owb_front: tick classifier
// Flags a tick whose request names a known command.
// ----------------------------------------------------------------------------
module owb_front import owb_pkg::*; (
  input  in_item_t item,
  output tick_t    tick
);

  always_comb begin
    tick.start_ok   = item.cmd_valid &&
                      (item.req_type == CMD_RESET || item.req_type == CMD_WBYTE ||
                       item.req_type == CMD_RBYTE || item.req_type == CMD_WBIT  ||
                       item.req_type == CMD_RBIT);
    tick.req_type   = item.req_type;
    tick.write_data = item.write_data;
    tick.line_level = item.line_level;
  end

endmodule

// ===== rtl/owb_queue.sv =====
// ----------------------------------------------------------------------------
// owb_queue: small tick queue
// Register-based FIFO between the classifier and the bus sequencer.
// ----------------------------------------------------------------------------
module owb_queue import owb_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  tick_t     push_data,
  input  logic      pop,
  output tick_t     pop_data,
  output q_status_t status
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  tick_t          slots [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign status.full  = (count == FullCnt);
  assign status.empty = (count == '0);
  assign pop_data     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/owb_back.sv =====
// ----------------------------------------------------------------------------
// owb_back: bus sequencer
// Steps the reset and bit-slot phases once per tick and forms the result.
// ----------------------------------------------------------------------------
module owb_back import owb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [TimeW-1:0] cfg_data,
  input  logic        step,
  input  tick_t       tick,
  output res_item_t   result
);

  timing_t          timing;
  logic [3:0]       phase, phase_next;
  logic [TimeW-1:0] phase_timer, phase_timer_next;
  logic [3:0]       bits_left, bits_left_next;
  logic [7:0]       shift_reg, shift_reg_next;
  logic [2:0]       active_cmd, active_cmd_next;
  logic             presence_flag, presence_flag_next;

  // Timing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      timing.reset_low_time       <= RST_RESET_LOW;
      timing.presence_sample_time <= RST_PRESENCE_SAMPLE;
      timing.reset_tail_time      <= RST_RESET_TAIL;
      timing.slot_low_time        <= RST_SLOT_LOW;
      timing.read_sample_time     <= RST_READ_SAMPLE;
      timing.write_hold_time      <= RST_WRITE_HOLD;
      timing.read_tail_time       <= RST_READ_TAIL;
      timing.recovery_time        <= RST_RECOVERY;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RESET_LOW:       timing.reset_low_time       <= cfg_data;
        REG_PRESENCE_SAMPLE: timing.presence_sample_time <= cfg_data;
        REG_RESET_TAIL:      timing.reset_tail_time      <= cfg_data;
        REG_SLOT_LOW:        timing.slot_low_time        <= cfg_data;
        REG_READ_SAMPLE:     timing.read_sample_time     <= cfg_data;
        REG_WRITE_HOLD:      timing.write_hold_time      <= cfg_data;
        REG_READ_TAIL:       timing.read_tail_time       <= cfg_data;
        REG_RECOVERY:        timing.recovery_time        <= cfg_data;
        default:             timing                      <= timing;
      endcase
    end
  end

  // One tick of the sequencer
  always_comb begin
    logic             start;
    logic [3:0]       ph;
    logic [TimeW-1:0] tmr;
    logic [3:0]       bits;
    logic [7:0]       sh;
    logic [2:0]       cmd;
    logic             pres;
    logic [TimeW-1:0] raw_len;
    logic [TimeW-1:0] len;
    logic [TimeW:0]   tmr_inc;
    logic             expire;
    logic             is_wr;
    logic             drive, busy, done;

    start = (phase == PH_IDLE) && tick.start_ok;
    ph    = phase;
    tmr   = phase_timer;
    bits  = bits_left;
    sh    = shift_reg;
    cmd   = active_cmd;
    pres  = presence_flag;
    drive = 1'b0;
    busy  = 1'b0;
    done  = 1'b0;

    // Take a new command only from idle
    if (start) begin
      cmd = tick.req_type;
      tmr = '0;
      if (tick.req_type == CMD_RESET) begin
        pres = 1'b0;
        ph   = PH_RST_LOW;
      end else begin
        ph   = PH_SLOT_LOW;
        bits = (tick.req_type == CMD_WBIT || tick.req_type == CMD_RBIT) ?
               BITS_ONE : BITS_BYTE;
        if (tick.req_type == CMD_WBYTE) begin
          sh = tick.write_data;
        end else if (tick.req_type == CMD_WBIT) begin
          sh = {7'd0, tick.write_data[0]};
        end else begin
          sh = '0;
        end
      end
    end

    is_wr = (cmd == CMD_WBYTE) || (cmd == CMD_WBIT);

    unique case (ph)
      PH_RST_LOW:  raw_len = timing.reset_low_time;
      PH_RST_WAIT: raw_len = timing.presence_sample_time;
      PH_RST_TAIL: raw_len = timing.reset_tail_time;
      PH_SLOT_LOW: raw_len = timing.slot_low_time;
      PH_WR_HOLD:  raw_len = timing.write_hold_time;
      PH_RD_WAIT:  raw_len = timing.read_sample_time;
      PH_RD_TAIL:  raw_len = timing.read_tail_time;
      PH_RECOVER:  raw_len = timing.recovery_time;
      default:     raw_len = TimeW'(1);
    endcase
    len     = (raw_len == '0) ? TimeW'(1) : raw_len;
    tmr_inc = {1'b0, tmr} + 1'b1;
    expire  = (tmr_inc >= {1'b0, len});

    if (ph != PH_IDLE) begin
      busy = 1'b1;
      if (ph == PH_RST_LOW || ph == PH_SLOT_LOW) begin
        drive = 1'b1;
      end else if (ph == PH_WR_HOLD) begin
        drive = ~sh[0];
      end
      tmr = tmr_inc[TimeW-1:0];
      if (expire) begin
        tmr = '0;
        unique case (ph)
          PH_RST_LOW:  ph = PH_RST_WAIT;
          PH_RST_WAIT: begin
            pres = tick.line_level;
            ph   = PH_RST_TAIL;
          end
          PH_RST_TAIL: begin
            ph   = PH_IDLE;
            done = 1'b1;
          end
          PH_SLOT_LOW: ph = is_wr ? PH_WR_HOLD : PH_RD_WAIT;
          PH_WR_HOLD: begin
            sh = {1'b0, sh[7:1]};
            if (bits != '0) bits = bits - 1'b1;
            ph = PH_RECOVER;
          end
          PH_RD_WAIT: begin
            sh = {tick.line_level, sh[7:1]};
            if (bits != '0) bits = bits - 1'b1;
            ph = PH_RD_TAIL;
          end
          PH_RD_TAIL:  ph = PH_RECOVER;
          PH_RECOVER: begin
            if (bits != '0) begin
              ph = PH_SLOT_LOW;
            end else begin
              ph   = PH_IDLE;
              done = 1'b1;
            end
          end
          default:     ph = PH_IDLE;
        endcase
      end
    end

    phase_next         = ph;
    phase_timer_next   = tmr;
    bits_left_next     = bits;
    shift_reg_next     = sh;
    active_cmd_next    = cmd;
    presence_flag_next = pres;

    result.drive_low   = drive;
    result.busy_res    = busy;
    result.done_res    = done;
    if (cmd == CMD_RBYTE) begin
      result.read_data = sh;
    end else if (cmd == CMD_RBIT) begin
      result.read_data = {7'd0, sh[7]};
    end else begin
      result.read_data = '0;
    end
    result.no_presence = pres;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      phase_timer   <= '0;
      bits_left     <= '0;
      shift_reg     <= '0;
      active_cmd    <= CMD_RESET;
      presence_flag <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      phase_timer   <= phase_timer_next;
      bits_left     <= bits_left_next;
      shift_reg     <= shift_reg_next;
      active_cmd    <= active_cmd_next;
      presence_flag <= presence_flag_next;
    end
  end

endmodule

// ===== rtl/one_wire_bus_master.sv =====
// ----------------------------------------------------------------------------
// one_wire_bus_master: 1-Wire bus master stepped once per microsecond tick
// Classifier, tick queue and bus sequencer with a registered result beat.
// ----------------------------------------------------------------------------
// Every input beat is one microsecond tick carrying a possible command request
// and the sampled bus level; every tick returns exactly one result beat with
// the open-drain pull-down, busy, done, read byte and presence status. The
// block takes one tick per clock cycle when the result side does not stall:
// the sequencer computes a whole tick combinationally from its phase timer
// (one 10-bit increment and compare), so it never holds the flow itself.
// A tick's result passes through the tick queue and then the result register.
// The queue, QUEUE_DEPTH ticks deep, lets the input side keep running while a
// result beat waits to be taken.
// Timing registers are written through cfg_we/cfg_index/cfg_data and are
// meant to change only while the bus is idle and no ticks are in flight.
module one_wire_bus_master import owb_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  // Tick channel
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  // Result channel
  output logic             res_valid,
  input  logic             res_stall,
  output res_item_t        res_data,
  // Configuration
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [TimeW-1:0] cfg_data
);

  tick_t     tick_in;
  tick_t     tick_out;
  q_status_t q_status;
  logic      push;
  logic      pop;
  res_item_t step_result;

  // Front: classify each tick beat on the way in
  owb_front u_front (
    .item (in_data),
    .tick (tick_in)
  );

  // Hold off the tick side only when the queue is full
  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full;

  owb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (tick_in),
    .pop       (pop),
    .pop_data  (tick_out),
    .status    (q_status)
  );

  // Back: advance the sequencer whenever a tick is queued and the result register can take a beat
  assign pop = !q_status.empty && (!res_valid || !res_stall);

  owb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (pop),
    .tick      (tick_out),
    .result    (step_result)
  );

  // Result register: load on a step, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pop) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_data <= step_result;
    end
  end

`ifndef NO_ASSERTIONS
  // A queued tick with room on the result side yields a result beat next cycle
  a_step_to_result: assert property (@(posedge clk) disable iff (rst)
    (!q_status.empty && (!res_valid || !res_stall)) |=> res_valid)
    else $error("queued tick did not produce a result beat");

  // The line is only pulled low during a command
  a_drive_while_busy: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.drive_low) |-> res_data.busy_res)
    else $error("drive_low outside a command");

  // Completion is reported on a busy tick
  a_done_while_busy: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.done_res) |-> res_data.busy_res)
    else $error("done_res without busy_res");

  // A waiting result beat is not overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |-> !pop)
    else $error("result register overwritten while stalled");
`endif

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the 1-Wire bus master
// Each beat into the block is one microsecond tick. Every accepted tick is run
// through a bus predictor kept in this file, and the predicted result beat is
// queued. Each result beat leaving the block is checked against the oldest
// queued beat. Timing registers are reprogrammed only with the bus idle and
// the result queue empty. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import owb_pkg::*;

  // Hang guard
  localparam int CYCLE_LIMIT = 1000000;
  localparam int MAX_REPORTS = 10;

  // How the bus line behaves while a directed command runs
  localparam int LINE_LOW  = 0;
  localparam int LINE_HIGH = 1;
  localparam int LINE_RAND = 2;

  localparam int RAND_ROUNDS     = 4;
  localparam int TICKS_PER_ROUND = 25;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_item_t         in_data = '0;
  logic             res_valid;
  logic             res_stall = 1'b0;
  res_item_t        res_data;
  logic             cfg_we = 1'b0;
  logic [2:0]       cfg_index = REG_RESET_LOW;
  logic [TimeW-1:0] cfg_data = '0;

  one_wire_bus_master dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // Bus predictor state: a private copy of the sequencer and its timings
  // --------------------------------------------------------------------------
  timing_t    bus_timing;
  logic [3:0] bus_phase;
  logic [9:0] bus_timer;
  logic [3:0] bus_bits;
  logic [7:0] bus_shift;
  logic [2:0] bus_cmd;
  logic       bus_presence;

  // Predicted result beats, oldest first
  res_item_t  bus_res_q[$];

  // Run bookkeeping
  int         cycle_count = 0;
  int         err_count = 0;
  int         ticks_sent = 0;
  int         beats_checked = 0;
  int         cmds_started = 0;
  int         timing_sets = 0;
  int         resets_no_dev = 0;
  bit         tx_quiet = 1'b0;
  bit         rx_quiet = 1'b0;
  int         rx_hold = 0;

  // Length of a timed phase; a register value of zero still costs one tick
  function automatic logic [9:0] phase_ticks(logic [3:0] ph);
    logic [9:0] d;
    case (ph)
      PH_RST_LOW:  d = bus_timing.reset_low_time;
      PH_RST_WAIT: d = bus_timing.presence_sample_time;
      PH_RST_TAIL: d = bus_timing.reset_tail_time;
      PH_SLOT_LOW: d = bus_timing.slot_low_time;
      PH_WR_HOLD:  d = bus_timing.write_hold_time;
      PH_RD_WAIT:  d = bus_timing.read_sample_time;
      PH_RD_TAIL:  d = bus_timing.read_tail_time;
      PH_RECOVER:  d = bus_timing.recovery_time;
      default:     d = 10'd1;
    endcase
    return (d == 10'd0) ? 10'd1 : d;
  endfunction

  // Advance the predicted bus by one tick and return the result beat it yields
  function automatic res_item_t step_bus(in_item_t t);
    res_item_t r;
    r = '0;
    // A start is taken only from idle and only for a known request
    if (bus_phase == PH_IDLE && t.cmd_valid && t.req_type <= CMD_RBIT) begin
      bus_cmd   = t.req_type;
      bus_timer = '0;
      cmds_started++;
      if (t.req_type == CMD_RESET) begin
        bus_presence = 1'b0;
        bus_phase    = PH_RST_LOW;
      end else begin
        bus_phase = PH_SLOT_LOW;
        bus_bits  = (t.req_type == CMD_WBIT || t.req_type == CMD_RBIT) ? BITS_ONE : BITS_BYTE;
        if (t.req_type == CMD_WBYTE)
          bus_shift = t.write_data;
        else if (t.req_type == CMD_WBIT)
          bus_shift = {7'd0, t.write_data[0]};
        else
          bus_shift = '0;
      end
    end

    if (bus_phase != PH_IDLE) begin
      r.busy_res = 1'b1;
      if (bus_phase == PH_RST_LOW || bus_phase == PH_SLOT_LOW)
        r.drive_low = 1'b1;
      else if (bus_phase == PH_WR_HOLD)
        r.drive_low = ~bus_shift[0];

      bus_timer = bus_timer + 10'd1;
      if (bus_timer >= phase_ticks(bus_phase)) begin
        bus_timer = '0;
        case (bus_phase)
          PH_RST_LOW:  bus_phase = PH_RST_WAIT;
          PH_RST_WAIT: begin
            bus_presence = t.line_level;
            if (t.line_level) resets_no_dev++;
            bus_phase = PH_RST_TAIL;
          end
          PH_RST_TAIL: begin
            bus_phase  = PH_IDLE;
            r.done_res = 1'b1;
          end
          PH_SLOT_LOW: begin
            bus_phase = (bus_cmd == CMD_WBYTE || bus_cmd == CMD_WBIT) ? PH_WR_HOLD : PH_RD_WAIT;
          end
          PH_WR_HOLD: begin
            bus_shift = {1'b0, bus_shift[7:1]};
            if (bus_bits != 4'd0) bus_bits = bus_bits - 4'd1;
            bus_phase = PH_RECOVER;
          end
          PH_RD_WAIT: begin
            // Read bits enter at the top and walk down, LSB first on the wire
            bus_shift = {t.line_level, bus_shift[7:1]};
            if (bus_bits != 4'd0) bus_bits = bus_bits - 4'd1;
            bus_phase = PH_RD_TAIL;
          end
          PH_RD_TAIL:  bus_phase = PH_RECOVER;
          PH_RECOVER: begin
            if (bus_bits != 4'd0) begin
              bus_phase = PH_SLOT_LOW;
            end else begin
              bus_phase  = PH_IDLE;
              r.done_res = 1'b1;
            end
          end
          default:     bus_phase = PH_IDLE;
        endcase
      end
    end

    // Read data only shows for reads; writes and resets show zero
    if (bus_cmd == CMD_RBYTE)
      r.read_data = bus_shift;
    else if (bus_cmd == CMD_RBIT)
      r.read_data = {7'd0, bus_shift[7]};
    else
      r.read_data = '0;
    r.no_presence = bus_presence;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Timing sets
  // --------------------------------------------------------------------------
  function automatic timing_t timing_at_reset();
    timing_t t;
    t.reset_low_time       = RST_RESET_LOW;
    t.presence_sample_time = RST_PRESENCE_SAMPLE;
    t.reset_tail_time      = RST_RESET_TAIL;
    t.slot_low_time        = RST_SLOT_LOW;
    t.read_sample_time     = RST_READ_SAMPLE;
    t.write_hold_time      = RST_WRITE_HOLD;
    t.read_tail_time       = RST_READ_TAIL;
    t.recovery_time        = RST_RECOVERY;
    return t;
  endfunction

  // Shortest legal timings: zero where allowed, else one
  function automatic timing_t timing_shortest();
    timing_t t;
    t.reset_low_time       = 10'd1;
    t.presence_sample_time = 10'd1;
    t.reset_tail_time      = 10'd0;
    t.slot_low_time        = 10'd1;
    t.read_sample_time     = 10'd0;
    t.write_hold_time      = 10'd1;
    t.read_tail_time       = 10'd0;
    t.recovery_time        = 10'd0;
    return t;
  endfunction

  // Small random timings keep many commands inside a round
  function automatic timing_t timing_small_rand();
    timing_t t;
    t.reset_low_time       = 10'($urandom_range(1, 6));
    t.presence_sample_time = 10'($urandom_range(1, 4));
    t.reset_tail_time      = 10'($urandom_range(0, 4));
    t.slot_low_time        = 10'($urandom_range(1, 3));
    t.read_sample_time     = 10'($urandom_range(0, 3));
    t.write_hold_time      = 10'($urandom_range(1, 4));
    t.read_tail_time       = 10'($urandom_range(0, 3));
    t.recovery_time        = 10'($urandom_range(0, 3));
    return t;
  endfunction

  // --------------------------------------------------------------------------
  // Shared drivers
  // --------------------------------------------------------------------------
  task automatic note_error(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("mismatch: %s", msg);
  endtask

  // Offer one tick beat; return once the block has taken it. Valid stays high
  // so that a back-to-back tick needs no extra edge.
  task automatic send_tick(input in_item_t t);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    bus_res_q.push_back(step_bus(t));
    ticks_sent++;
  endtask

  // Drop valid right at the edge that took the last beat
  task automatic quiet_input();
    in_valid <= 1'b0;
  endtask

  // Hold off until every predicted beat has come back, then let the pipe settle
  task automatic drain();
    while (bus_res_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [TimeW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // Reprogram all eight timing registers with the bus idle and the pipe empty
  task automatic program_timing(input timing_t t);
    quiet_input();
    drain();
    write_reg(REG_RESET_LOW,       t.reset_low_time);
    write_reg(REG_PRESENCE_SAMPLE, t.presence_sample_time);
    write_reg(REG_RESET_TAIL,      t.reset_tail_time);
    write_reg(REG_SLOT_LOW,        t.slot_low_time);
    write_reg(REG_READ_SAMPLE,     t.read_sample_time);
    write_reg(REG_WRITE_HOLD,      t.write_hold_time);
    write_reg(REG_READ_TAIL,       t.read_tail_time);
    write_reg(REG_RECOVERY,        t.recovery_time);
    cfg_we <= 1'b0;
    @(posedge clk);
    bus_timing = t;
    timing_sets++;
  endtask

  function automatic logic pick_line(input int mode);
    return (mode == LINE_RAND) ? 1'($urandom_range(0, 1)) : (mode == LINE_HIGH);
  endfunction

  // Start one command and tick the bus until it is idle again. With poke set,
  // fresh requests are thrown at the busy master and must be ignored.
  task automatic issue_cmd(input logic [2:0] req, input logic [7:0] data,
                           input int line_mode, input bit poke);
    in_item_t t;
    t.cmd_valid  = 1'b1;
    t.req_type   = req;
    t.write_data = data;
    t.line_level = pick_line(line_mode);
    send_tick(t);
    while (bus_phase != PH_IDLE) begin
      t.cmd_valid  = poke ? 1'($urandom_range(0, 1)) : 1'b0;
      t.req_type   = 3'($urandom_range(0, 7));
      t.write_data = 8'($urandom);
      t.line_level = pick_line(line_mode);
      send_tick(t);
    end
  endtask

  // Mostly well-formed starts from idle, noise while busy
  function automatic in_item_t random_tick();
    in_item_t t;
    int roll;
    roll         = $urandom_range(0, 9);
    t.write_data = 8'($urandom);
    t.line_level = 1'($urandom_range(0, 1));
    if (bus_phase == PH_IDLE) begin
      if (roll < 8) begin
        t.cmd_valid = 1'b1;
        t.req_type  = 3'($urandom_range(0, 4));
      end else if (roll == 8) begin
        // unknown request, ignored
        t.cmd_valid = 1'b1;
        t.req_type  = 3'($urandom_range(5, 7));
      end else begin
        t.cmd_valid = 1'b0;
        t.req_type  = 3'($urandom_range(0, 7));
      end
    end else begin
      t.cmd_valid = (roll < 3);
      t.req_type  = 3'($urandom_range(0, 7));
    end
    return t;
  endfunction

  task automatic finish_bus();
    while (bus_phase != PH_IDLE) send_tick(random_tick());
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset timings: the reset pulse and both single-bit slots at full length
  task automatic test_reset_timing();
    issue_cmd(CMD_RESET, 8'h00, LINE_LOW, 1'b1);
    issue_cmd(CMD_WBIT,  8'h01, LINE_RAND, 1'b0);
    issue_cmd(CMD_RBIT,  8'h00, LINE_HIGH, 1'b0);
  endtask

  // Shortest timings: data extremes, presence both ways, unknown requests
  task automatic test_short_timing();
    program_timing(timing_shortest());
    issue_cmd(CMD_RESET, 8'h00, LINE_LOW,  1'b0);
    issue_cmd(CMD_RESET, 8'hFF, LINE_HIGH, 1'b1);
    issue_cmd(CMD_WBYTE, 8'h00, LINE_RAND, 1'b0);
    issue_cmd(CMD_WBYTE, 8'hFF, LINE_RAND, 1'b1);
    issue_cmd(CMD_RBYTE, 8'h00, LINE_HIGH, 1'b0);
    issue_cmd(CMD_WBYTE, 8'hA5, LINE_RAND, 1'b0);
    issue_cmd(CMD_RBYTE, 8'hFF, LINE_LOW,  1'b1);
    issue_cmd(CMD_RBYTE, 8'h5A, LINE_RAND, 1'b0);
    issue_cmd(CMD_WBIT,  8'hFE, LINE_RAND, 1'b0);
    issue_cmd(CMD_WBIT,  8'h01, LINE_RAND, 1'b1);
    issue_cmd(CMD_RBIT,  8'h00, LINE_HIGH, 1'b0);
    issue_cmd(CMD_RBIT,  8'hFF, LINE_LOW,  1'b0);
    issue_cmd(3'd5, 8'h00, LINE_RAND, 1'b0);
    issue_cmd(3'd6, 8'hFF, LINE_RAND, 1'b0);
    issue_cmd(3'd7, 8'h81, LINE_RAND, 1'b0);
    issue_cmd(CMD_RESET, 8'h00, LINE_RAND, 1'b1);
  endtask

  // Hold the result side off for a long stretch while ticks keep coming,
  // so the queue fills and the input stalls; then pause until all are back
  task automatic test_backpressure();
    program_timing(timing_small_rand());
    rx_hold  = 300;
    tx_quiet = 1'b1;
    repeat (100) send_tick(random_tick());
    tx_quiet = 1'b0;
    finish_bus();
    quiet_input();
    drain();
    repeat (30) send_tick(random_tick());
    finish_bus();
  endtask

  // Random rounds, each with its own small timing set and idling mix
  task automatic test_random_rounds();
    for (int round = 0; round < RAND_ROUNDS; round++) begin
      program_timing(timing_small_rand());
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      repeat (TICKS_PER_ROUND) send_tick(random_tick());
      finish_bus();
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls per beat, plus the long hold on request
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int n;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        n       = rx_hold;
        rx_hold = 0;
        res_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      n = rx_quiet ? 0 : $urandom_range(0, 5);
      if (n > 0) begin
        res_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      res_stall <= 1'b0;
      // wait for the beat this release lets through
      @(posedge clk);
      while (res_valid !== 1'b1) @(posedge clk);
    end
  end

  // Check every beat the block hands over against the oldest prediction
  res_item_t want_beat;
  always @(posedge clk) begin
    if (!rst && res_valid === 1'b1 && res_stall === 1'b0) begin
      if (bus_res_q.size() == 0) begin
        note_error($sformatf("result beat %p with nothing predicted", res_data));
      end else begin
        want_beat = bus_res_q.pop_front();
        beats_checked++;
        if (res_data.drive_low !== want_beat.drive_low ||
            res_data.busy_res !== want_beat.busy_res ||
            res_data.done_res !== want_beat.done_res ||
            res_data.read_data !== want_beat.read_data ||
            res_data.no_presence !== want_beat.no_presence) begin
          note_error($sformatf(
            "beat %0d: drive_low %b/%b busy %b/%b done %b/%b read %h/%h no_presence %b/%b",
            beats_checked, want_beat.drive_low, res_data.drive_low,
            want_beat.busy_res, res_data.busy_res, want_beat.done_res, res_data.done_res,
            want_beat.read_data, res_data.read_data,
            want_beat.no_presence, res_data.no_presence));
        end
      end
    end
  end

  // Hang guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
               bus_res_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    bus_timing   = timing_at_reset();
    bus_phase    = PH_IDLE;
    bus_timer    = '0;
    bus_bits     = '0;
    bus_shift    = '0;
    bus_cmd      = CMD_RESET;
    bus_presence = 1'b0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_timing();
    test_short_timing();
    test_backpressure();
    test_random_rounds();

    quiet_input();
    drain();
    repeat (8) @(posedge clk);
    if (bus_res_q.size() != 0)
      note_error($sformatf("%0d predicted beats never arrived", bus_res_q.size()));

    $display("covered %0d ticks, %0d commands, %0d resets without a device, %0d timing sets",
             ticks_sent, cmds_started, resets_no_dev, timing_sets);
    $display("checked %0d result beats, %0d mismatches", beats_checked, err_count);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
